@@ rtl/range_distinct_count_window_top_defines.svh @@
// Assertion macros used by the checker file of the range distinct-count block.
`ifndef RANGE_DISTINCT_COUNT_WINDOW_TOP_DEFINES_SVH
`define RANGE_DISTINCT_COUNT_WINDOW_TOP_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define RDCW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RDCW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/rdcw_pkg.sv @@
// Shared constants of the range distinct-count window block.
`default_nettype none

package rdcw_pkg;

  localparam int unsigned STORE_SIZE_DEF  = 1024;
  localparam int unsigned VALUE_RANGE_DEF = 1024;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned VAL_W   = 10;
  localparam int unsigned RANGE_W = 11;
  localparam int unsigned COUNT_W = 11;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

`default_nettype wire

@@ rtl/rdcw_if.sv @@
// Valid/ready channel interfaces for the range distinct-count window block.
`default_nettype none

interface rdcw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [rdcw_pkg::POS_W-1:0]    position;
  logic [rdcw_pkg::VAL_W-1:0]    element_value;
  logic [rdcw_pkg::RANGE_W-1:0]  range_left;
  logic [rdcw_pkg::RANGE_W-1:0]  range_right;

  modport source (output valid, mode, position, element_value, range_left, range_right,
                  input ready);
  modport sink   (input valid, mode, position, element_value, range_left, range_right,
                  output ready);
endinterface

interface rdcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rdcw_pkg::COUNT_W-1:0]  distinct_count;
  logic                          bad_range;

  modport source (output valid, distinct_count, bad_range, input ready);
  modport sink   (input valid, distinct_count, bad_range, output ready);
endinterface

`default_nettype wire

@@ rtl/range_distinct_count_window_top.sv @@
// Top level of the range distinct-count window block.
`default_nettype none

// Counts distinct values over a half-open window [left, right) of an element
// store. A load transfer (mode 0) writes one element and produces no result;
// a query transfer (mode 1) walks the window edges to the requested range,
// widening before shrinking, and returns the distinct count. The element store
// and the per-value occurrence counts live in two RAMs with registered read data.
// After reset a clearing pass zeroes both RAMs with in_i.ready low. A load
// outside the window is written as it is accepted; a load inside it goes
// through accept, element read, old-value count update, new-value count
// read and new-value count update. A query repeats element read, count
// read and count write back for each element step, where the number of
// steps is |left - old left| + |right - old right|; a flagged query goes
// straight to its result.
// Results are delivered in arrival order, and a new item is taken while a
// finished result still waits in the output register.
module range_distinct_count_window_top #(
  parameter int unsigned STORE_SIZE  = rdcw_pkg::STORE_SIZE_DEF,
  parameter int unsigned VALUE_RANGE = rdcw_pkg::VALUE_RANGE_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rdcw_in_if.sink    in_i,
  rdcw_out_if.source out_o
);

  localparam int unsigned AW        = $clog2(STORE_SIZE);
  localparam int unsigned VW        = $clog2(VALUE_RANGE);
  localparam int unsigned CW        = $clog2(STORE_SIZE + 1);
  localparam int unsigned CLR_DEPTH = (STORE_SIZE > VALUE_RANGE) ? STORE_SIZE : VALUE_RANGE;
  localparam int unsigned CLRW      = $clog2(CLR_DEPTH);
  localparam int unsigned RW        = rdcw_pkg::RANGE_W;
  localparam int unsigned VALW      = rdcw_pkg::VAL_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FETCH,
    ST_COUNT,
    ST_LOAD_NEW,
    ST_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [CLRW-1:0]              clr_q, clr_d;
  logic [RW-1:0]                wlo_q, wlo_d, whi_q, whi_d;
  logic [RW-1:0]                lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]                tally_q, tally_d;
  logic [rdcw_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [VALW-1:0]              val_q, val_d;
  logic [VALW-1:0]              cval_q, cval_d;
  logic                         inc_q, inc_d;
  logic                         load_q, load_d;
  logic                         second_q, second_d;
  logic [rdcw_pkg::COUNT_W-1:0] res_cnt_q, res_cnt_d;
  logic                         res_bad_q, res_bad_d;
  logic                         out_valid_q, out_valid_d;
  logic [rdcw_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                         out_bad_q, out_bad_d;

  // Memory ports
  logic            e_we;
  logic [AW-1:0]   e_waddr, e_raddr;
  logic [VALW-1:0] e_wdata, e_rdata;
  logic            c_we;
  logic [VW-1:0]   c_waddr, c_raddr;
  logic [CW-1:0]   c_wdata, c_rdata;

  // Helpers
  logic [RW-1:0]   walk_idx;
  logic [31:0]     walk_idx32, in_pos32, pos_q32, clr32;
  logic [VALW-1:0] c_rval;
  logic [31:0]     c_rval32, cval32, tally32;
  logic            in_xfer, out_xfer;
  logic            load_ok, in_window, query_bad;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;

  assign in_pos32 = 32'(in_i.position);
  assign pos_q32  = 32'(pos_q);
  assign clr32    = 32'(clr_q);
  assign cval32   = 32'(cval_q);
  assign tally32  = 32'(tally_q);

  assign load_ok   = (in_pos32 < 32'(STORE_SIZE)) &&
                     (32'(in_i.element_value) < 32'(VALUE_RANGE));
  assign in_window = (RW'(in_i.position) >= wlo_q) && (RW'(in_i.position) < whi_q);
  assign query_bad = (in_i.range_left > in_i.range_right) ||
                     (32'(in_i.range_right) > 32'(STORE_SIZE));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wlo_d       = wlo_q;
    whi_d       = whi_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tally_d     = tally_q;
    pos_d       = pos_q;
    val_d       = val_q;
    cval_d      = cval_q;
    inc_d       = inc_q;
    load_d      = load_q;
    second_d    = second_q;
    res_cnt_d   = res_cnt_q;
    res_bad_d   = res_bad_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_cnt_d   = out_cnt_q;
    out_bad_d   = out_bad_q;

    walk_idx  = wlo_q;
    e_we      = 1'b0;
    e_waddr   = pos_q32[AW-1:0];
    e_wdata   = val_q;
    e_raddr   = in_pos32[AW-1:0];
    c_we      = 1'b0;
    c_waddr   = cval32[VW-1:0];
    c_wdata   = '0;
    c_rval    = e_rdata;

    unique case (state_q)
      ST_CLEAR: begin
        e_we    = clr32 < 32'(STORE_SIZE);
        e_waddr = clr32[AW-1:0];
        e_wdata = '0;
        c_we    = clr32 < 32'(VALUE_RANGE);
        c_waddr = clr32[VW-1:0];
        c_wdata = '0;
        clr_d   = clr_q + CLRW'(1);
        if (clr32 == 32'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Element read at the load position starts here in case it is needed.
        if (in_xfer) begin
          if (in_i.mode == rdcw_pkg::MODE_LOAD) begin
            if (load_ok) begin
              pos_d = in_i.position;
              val_d = in_i.element_value;
              if (in_window) begin
                load_d   = 1'b1;
                second_d = 1'b0;
                inc_d    = 1'b0;
                state_d  = ST_FETCH;
              end else begin
                e_we    = 1'b1;
                e_waddr = in_pos32[AW-1:0];
                e_wdata = in_i.element_value;
              end
            end
          end else if (query_bad) begin
            res_cnt_d = '0;
            res_bad_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            lo_d    = in_i.range_left;
            hi_d    = in_i.range_right;
            load_d  = 1'b0;
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // Widen first, then shrink; one edge step per pass.
        state_d = ST_FETCH;
        priority if (lo_q < wlo_q) begin
          walk_idx = wlo_q - RW'(1);
          wlo_d    = wlo_q - RW'(1);
          inc_d    = 1'b1;
        end else if (whi_q < hi_q) begin
          walk_idx = whi_q;
          whi_d    = whi_q + RW'(1);
          inc_d    = 1'b1;
        end else if (wlo_q < lo_q) begin
          walk_idx = wlo_q;
          wlo_d    = wlo_q + RW'(1);
          inc_d    = 1'b0;
        end else if (hi_q < whi_q) begin
          walk_idx = whi_q - RW'(1);
          whi_d    = whi_q - RW'(1);
          inc_d    = 1'b0;
        end else begin
          res_cnt_d = tally32[rdcw_pkg::COUNT_W-1:0];
          res_bad_d = 1'b0;
          state_d   = ST_DONE;
        end
        e_raddr = walk_idx32[AW-1:0];
      end

      ST_FETCH: begin
        // Element data is back; look up its count.
        cval_d  = e_rdata;
        c_rval  = e_rdata;
        state_d = ST_COUNT;
      end

      ST_COUNT: begin
        if (inc_q) begin
          c_we    = 1'b1;
          c_wdata = c_rdata + CW'(1);
          if (c_rdata == '0) begin
            tally_d = tally_q + CW'(1);
          end
        end else if (c_rdata != '0) begin
          c_we    = 1'b1;
          c_wdata = c_rdata - CW'(1);
          if (c_rdata == CW'(1) && tally_q != '0) begin
            tally_d = tally_q - CW'(1);
          end
        end
        if (!load_q) begin
          state_d = ST_WALK;
        end else if (second_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LOAD_NEW;
        end
      end

      ST_LOAD_NEW: begin
        // Count in the new value and commit the element.
        e_we     = 1'b1;
        cval_d   = val_q;
        c_rval   = val_q;
        inc_d    = 1'b1;
        second_d = 1'b1;
        state_d  = ST_COUNT;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = res_cnt_q;
          out_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    c_raddr = c_rval32[VW-1:0];
  end

  assign walk_idx32 = 32'(walk_idx);
  assign c_rval32   = 32'(c_rval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wlo_q       <= '0;
      whi_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      tally_q     <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      cval_q      <= '0;
      inc_q       <= 1'b0;
      load_q      <= 1'b0;
      second_q    <= 1'b0;
      res_cnt_q   <= '0;
      res_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_cnt_q   <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wlo_q       <= wlo_d;
      whi_q       <= whi_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      tally_q     <= tally_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      cval_q      <= cval_d;
      inc_q       <= inc_d;
      load_q      <= load_d;
      second_q    <= second_d;
      res_cnt_q   <= res_cnt_d;
      res_bad_q   <= res_bad_d;
      out_valid_q <= out_valid_d;
      out_cnt_q   <= out_cnt_d;
      out_bad_q   <= out_bad_d;
    end
  end

  // Element store: one value per position.
  rdcw_ram #(
    .WIDTH (VALW),
    .DEPTH (STORE_SIZE)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Occurrence counts: one per value, for the elements inside the window.
  rdcw_ram #(
    .WIDTH (CW),
    .DEPTH (VALUE_RANGE)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.distinct_count = out_cnt_q;
  assign out_o.bad_range      = out_bad_q;

endmodule

`default_nettype wire

@@ rtl/rdcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rdcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/rdcw_checker.sv @@
// Port-level assertion checker for the range distinct-count window block, with its bind.
`default_nettype none
`include "range_distinct_count_window_top_defines.svh"

module rdcw_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [rdcw_pkg::COUNT_W-1:0] distinct_count_i,
  input wire logic                         bad_range_i
);

  // Hold a stalled result valid.
  `RDCW_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "out valid dropped while stalled")

  // Hold a stalled result payload.
  `RDCW_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(distinct_count_i) && $stable(bad_range_i), "out payload changed while stalled")

  // A flagged query carries a zero count.
  `RDCW_ASSERT(a_bad_zero, clk_i, rst_ni, out_valid_i && bad_range_i |-> distinct_count_i == '0, "flagged result with nonzero count")

  // The clearing pass after reset takes no input.
  `RDCW_ASSERT_ALWAYS(a_clear_block, clk_i, !rst_ni |=> !in_ready_i, "input ready during clearing pass")

endmodule

bind range_distinct_count_window_top rdcw_checker u_rdcw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .distinct_count_i (out_o.distinct_count),
  .bad_range_i      (out_o.bad_range)
);

`default_nettype wire
